/* rtl/trimmed_mean_window_filter_core_macros.svh */
`ifndef TRIMMED_MEAN_WINDOW_FILTER_CORE_MACROS_SVH
`define TRIMMED_MEAN_WINDOW_FILTER_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define TMWF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define TMWF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/tmwf_pkg.sv */
`timescale 1ns / 1ps

package tmwf_pkg;

  localparam int unsigned SampleW = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } tmwf_state_t;

  typedef struct packed {
    logic start;     // write the accepted sample and clear the accumulators
    logic scan;      // read the next window entry
    logic load_out;  // move the finished result into the output register
  } tmwf_cmd_t;

  typedef struct packed {
    logic last_addr; // the scan address is on the final entry
    logic out_free;  // the output register can take a result this cycle
  } tmwf_sts_t;

endpackage

/* rtl/tmwf_ram.sv */
`timescale 1ns / 1ps

module tmwf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tmwf_ctrl.sv */
`timescale 1ns / 1ps

`include "trimmed_mean_window_filter_core_macros.svh"

module tmwf_ctrl
  import tmwf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  tmwf_sts_t sts,
  output tmwf_cmd_t cmd
);

  tmwf_state_t state;
  tmwf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      ST_IDLE: begin
        // No item is taken while reset is high.
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last_addr) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `TMWF_ASSERT(a_accept_scan, in_valid && in_ready |=> state == ST_SCAN, "no scan after item")
  `TMWF_ASSERT(a_load_needs_room, cmd.load_out |-> sts.out_free, "load without room")
  `TMWF_ASSERT(a_drain_result, state == ST_DRAIN |=> state == ST_RESULT, "drain without result")
  `TMWF_ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.start, cmd.scan, cmd.load_out}), "command clash")

endmodule

/* rtl/tmwf_dp.sv */
`timescale 1ns / 1ps

module tmwf_dp
  import tmwf_pkg::*;
#(
  parameter int unsigned WINDOW = 10,
  parameter int unsigned SHIFT  = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  tmwf_cmd_t          cmd,
  output tmwf_sts_t          sts,
  input  logic [SampleW-1:0] sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SampleW-1:0] filtered
);

  localparam int unsigned AW   = $clog2(WINDOW);
  localparam int unsigned SUMW = SampleW + $clog2(WINDOW);

  logic [AW-1:0]      write_pos;
  logic [AW-1:0]      wp_next;
  logic [WINDOW-1:0]  valid_bits;
  logic [AW-1:0]      cnt;
  logic               dv;
  logic               rd_valid;
  logic [SampleW-1:0] rdata;
  logic [SampleW-1:0] rd_value;
  logic [SUMW-1:0]    acc_sum;
  logic [SampleW-1:0] acc_max;
  logic [SampleW-1:0] acc_min;
  logic [SUMW:0]      diff;
  logic [SUMW-1:0]    shifted;
  logic [SampleW-1:0] result;

  assign wp_next = (write_pos == AW'(WINDOW - 1)) ? '0 : write_pos + AW'(1);

  tmwf_ram #(
    .WIDTH(SampleW),
    .DEPTH(WINDOW)
  ) u_window (
    .clk  (clk),
    .we   (cmd.start),
    .waddr(wp_next),
    .wdata(sample),
    .raddr(cnt),
    .rdata(rdata)
  );

  // Entries never written since reset read as zero.
  assign rd_value = rd_valid ? rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos  <= '0;
      valid_bits <= '0;
      cnt        <= '0;
      dv         <= 1'b0;
    end else begin
      dv <= cmd.scan;
      if (cmd.start) begin
        write_pos           <= wp_next;
        valid_bits[wp_next] <= 1'b1;
        cnt                 <= '0;
      end else if (cmd.scan) begin
        // The scan address wraps so that it never leaves the window.
        cnt <= sts.last_addr ? '0 : cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= valid_bits[cnt];
    if (cmd.start) begin
      acc_sum <= '0;
      acc_max <= '0;
      acc_min <= '1;
    end else if (dv) begin
      acc_sum <= acc_sum + SUMW'(rd_value);
      if (rd_value > acc_max) begin
        acc_max <= rd_value;
      end
      if (rd_value < acc_min) begin
        acc_min <= rd_value;
      end
    end
  end

  assign diff    = {1'b0, acc_sum} - (SUMW + 1)'(acc_max) - (SUMW + 1)'(acc_min);
  assign shifted = diff[SUMW] ? '0 : (diff[SUMW-1:0] >> SHIFT);
  assign result  = (|shifted[SUMW-1:SampleW]) ? '1 : shifted[SampleW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      filtered <= result;
    end
  end

  assign sts.last_addr = (cnt == AW'(WINDOW - 1));
  assign sts.out_free  = !out_valid || out_ready;

endmodule

/* rtl/trimmed_mean_window_filter_core.sv */
`timescale 1ns / 1ps

// Trimmed-mean moving-average filter. Each accepted item carries one 16-bit
// unsigned sample, which replaces the oldest entry of a circular window of
// WINDOW samples; the window reads as all zeros after reset, so the first
// results include those zeros. Every item yields exactly one result item,
// filtered, equal to the sum of the window minus its largest and its smallest
// entry, shifted right by SHIFT and saturated to 65535. The block handles one
// item at a time: it writes the sample, reads the window back through the
// single read port of the sample RAM while the sum, maximum and minimum
// accumulate, lets the last read land, and then loads the result into the
// output register, waiting while that register still holds an untaken result.
// The result sits in an output register, so the next item is taken as soon as
// the result is loaded, even if the previous result has not yet been taken.
// The cleared window after reset comes from one valid bit per entry, so no
// clearing pass is needed and the block accepts an item in the first cycle
// after reset.

module trimmed_mean_window_filter_core
  import tmwf_pkg::*;
#(
  parameter int unsigned WINDOW = 10,
  parameter int unsigned SHIFT  = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SampleW-1:0] sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SampleW-1:0] filtered
);

  // Command and status traffic between the sequencer and the datapath.
  tmwf_cmd_t cmd;
  tmwf_sts_t sts;

  // The sequencer steps through write, scan, drain and result for each item.
  tmwf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // The datapath holds the window RAM, the accumulators and the output register.
  tmwf_dp #(
    .WINDOW(WINDOW),
    .SHIFT (SHIFT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .sample   (sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .filtered (filtered)
  );

endmodule
